[sv/rre_pkg.sv]
// package of shared types, constants and rom builder functions for the estimate unit
package rre_pkg;

    localparam int SIG_BITS = 23;
    localparam int EXP_BITS = 8;
    localparam int EXP_BIAS = (1 << (EXP_BITS - 1)) - 1;
    localparam int INDEX_BITS_DEF = 7;
    localparam int EST_BITS_DEF = 7;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] MAXF_BITS = 32'h7F7F_FFFF;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

    localparam logic [1:0] RM_RNE = 2'd0;
    localparam logic [1:0] RM_RTZ = 2'd1;
    localparam logic [1:0] RM_RDN = 2'd2;
    localparam logic [1:0] RM_RUP = 2'd3;

    localparam logic FUNC_RCP = 1'b0;
    localparam logic FUNC_RSQ = 1'b1;

    typedef struct packed {
        logic                     func;
        logic                     sign;
        logic [1:0]               rm;
        logic                     is_inf;
        logic                     is_nan;
        logic                     is_snan;
        logic                     is_zero;
        logic                     is_sub;
        logic [SIG_BITS-1:0]      sig_n;
        logic signed [9:0]        e;
    } dec_t;

    typedef struct packed {
        logic                     func;
        logic                     sign;
        logic [1:0]               rm;
        logic                     is_inf;
        logic                     is_nan;
        logic                     is_snan;
        logic                     is_zero;
        logic                     tiny;
        logic [SIG_BITS-1:0]      os;
        logic signed [9:0]        oe_rcp;
        logic [EXP_BITS-1:0]      oe_rsq;
    } lkp_t;

    typedef struct packed {
        logic [31:0] result;
        logic        flag_invalid;
        logic        flag_div_zero;
        logic        flag_overflow;
        logic        flag_inexact;
    } res_t;

    function automatic logic [63:0] rcp_err(input logic [63:0] c, input logic [63:0] l,
                                            input logic [63:0] r, input logic [63:0] d);
        logic [63:0] cl;
        logic [63:0] cr;
        logic [63:0] el;
        logic [63:0] er;
        cl = c * l;
        cr = c * r;
        el = (cl > d) ? cl - d : d - cl;
        er = (cr > d) ? cr - d : d - cr;
        return (el > er) ? el : er;
    endfunction

    function automatic int sqrt_sum_sign(input logic [63:0] u, input logic [63:0] v,
                                         input logic [63:0] w);
        logic [63:0]  d;
        logic [127:0] l;
        logic [127:0] r;
        if (u + v > w)
            return 1;
        d = w - u - v;
        l = (128'(u) * 128'(v)) << 2;
        r = 128'(d) * 128'(d);
        if (l < r)
            return -1;
        if (l > r)
            return 1;
        return 0;
    endfunction

    function automatic logic [31:0] rcp_entry(input int i, input int ib, input int eb);
        logic [63:0] base;
        logic [63:0] top;
        logic [63:0] l;
        logic [63:0] r;
        logic [63:0] d;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] mid;
        base = 64'd1 << eb;
        top  = (64'd1 << (eb + 1)) - 64'd1;
        l    = (64'd1 << ib) + 64'(i);
        r    = l + 64'd1;
        d    = 64'd1 << (eb + ib + 1);
        a    = base;
        b    = top;
        for (int k = 0; k < 64; k++)
        begin
            if (a < b)
            begin
                mid = a + ((b - a + 64'd1) >> 1);
                if (mid * (l + r) <= (d << 1))
                    a = mid;
                else
                    b = mid - 64'd1;
            end
        end
        if (a < top && rcp_err(a + 64'd1, l, r, d) < rcp_err(a, l, r, d))
            a = a + 64'd1;
        return 32'(a - base);
    endfunction

    function automatic logic [31:0] rsq_entry(input int i, input int ib, input int eb);
        logic [63:0] base;
        logic [63:0] top;
        logic [63:0] m;
        logic [63:0] al;
        logic [63:0] ar;
        logic [63:0] t2;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] mid;
        base = 64'd1 << eb;
        top  = (64'd1 << (eb + 1)) - 64'd1;
        m    = 64'(i) & ((64'd1 << (ib - 1)) - 64'd1);
        al   = (64'd1 << (ib - 1)) + m;
        ar   = al + 64'd1;
        t2   = 64'd1 << (2 * eb + ib + 3);
        if (((i >> (ib - 1)) & 1) != 0)
        begin
            al = al << 1;
            ar = ar << 1;
        end
        a = base;
        b = top;
        for (int k = 0; k < 64; k++)
        begin
            if (a < b)
            begin
                mid = a + ((b - a + 64'd1) >> 1);
                if (sqrt_sum_sign(mid * mid * al, mid * mid * ar, t2) <= 0)
                    a = mid;
                else
                    b = mid - 64'd1;
            end
        end
        if (a < top && sqrt_sum_sign((a + 64'd1) * (a + 64'd1) * ar, a * a * al, t2) < 0)
            a = a + 64'd1;
        return 32'(a - base);
    endfunction

endpackage

[sv/rre_req_if.sv]
// operand channel interface
interface rre_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] operand;
    logic [1:0]  round_mode;

    modport source (output valid, output func, output operand, output round_mode,
                    input ready);
    modport sink (input valid, input func, input operand, input round_mode,
                  output ready);
endinterface

[sv/rre_rsp_if.sv]
// result channel interface
interface rre_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic        flag_invalid;
    logic        flag_div_zero;
    logic        flag_overflow;
    logic        flag_inexact;

    modport source (output valid, output result, output flag_invalid, output flag_div_zero,
                    output flag_overflow, output flag_inexact, input ready);
    modport sink (input valid, input result, input flag_invalid, input flag_div_zero,
                  input flag_overflow, input flag_inexact, output ready);
endinterface

[sv/recip_rsqrt_estimate.sv]
// reciprocal and rsqrt estimate unit, three register stages
// throughput: one beat per cycle unless rsp.ready stalls the pipeline;
// stage 1 leading-zero count and normalize,
// stage 2 rom lookup and exponent, stage 3 special cases and result
// reset: rst_n clears all stage valid bits, roms are constant logic
module recip_rsqrt_estimate #(
    parameter int INDEX_BITS = rre_pkg::INDEX_BITS_DEF,
    parameter int EST_BITS   = rre_pkg::EST_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rre_req_if.sink   req,
    rre_rsp_if.source rsp
);

    localparam int ROM_SIZE = 1 << INDEX_BITS;
    localparam int SB = rre_pkg::SIG_BITS;

    logic [EST_BITS-1:0] rcp_tab [ROM_SIZE];
    logic [EST_BITS-1:0] rsq_tab [ROM_SIZE];

    for (genvar g = 0; g < ROM_SIZE; g++)
    begin : g_rom
        localparam logic [31:0] RCP_V = rre_pkg::rcp_entry(g, INDEX_BITS, EST_BITS);
        localparam logic [31:0] RSQ_V = rre_pkg::rsq_entry(g, INDEX_BITS, EST_BITS);
        assign rcp_tab[g] = RCP_V[EST_BITS-1:0];
        assign rsq_tab[g] = RSQ_V[EST_BITS-1:0];
    end

    logic           v1_reg, v2_reg, v3_reg;
    rre_pkg::dec_t  s1_reg, s1_next;
    rre_pkg::lkp_t  s2_reg, s2_next;
    rre_pkg::res_t  s3_reg, s3_next;
    logic           rdy1, rdy2, rdy3;

    assign rdy3 = !v3_reg || rsp.ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign req.ready = rdy1;

    // stage 1: classify and normalize
    logic [SB-1:0] sig;
    logic [7:0]    ebits;
    logic [4:0]    lz;
    logic          found;

    always_comb
    begin
        sig   = req.operand[SB-1:0];
        ebits = req.operand[30:23];
        lz    = 5'd0;
        found = 1'b0;
        for (int k = SB - 1; k >= 0; k--)
        begin
            if (!found && sig[k])
            begin
                lz    = 5'(SB - 1 - k);
                found = 1'b1;
            end
        end
        s1_next.func    = req.func;
        s1_next.sign    = req.operand[31];
        s1_next.rm      = req.round_mode;
        s1_next.is_inf  = (ebits == 8'hFF) && (sig == '0);
        s1_next.is_nan  = (ebits == 8'hFF) && (sig != '0);
        s1_next.is_snan = !sig[SB-1];
        s1_next.is_zero = (ebits == 8'h00) && (sig == '0);
        s1_next.is_sub  = (ebits == 8'h00);
        if (ebits == 8'h00)
        begin
            s1_next.sig_n = SB'(sig << (lz + 5'd1));
            s1_next.e     = -$signed({5'd0, lz});
        end
        else
        begin
            s1_next.sig_n = sig;
            s1_next.e     = $signed({2'b00, ebits});
        end
    end

    // stage 2: rom lookup and exponent
    logic [INDEX_BITS-1:0] idx_rcp, idx_rsq;

    always_comb
    begin
        idx_rcp         = s1_reg.sig_n[SB-1 -: INDEX_BITS];
        idx_rsq         = {~s1_reg.e[0], s1_reg.sig_n[SB-1 -: (INDEX_BITS - 1)]};
        s2_next.func    = s1_reg.func;
        s2_next.sign    = s1_reg.sign;
        s2_next.rm      = s1_reg.rm;
        s2_next.is_inf  = s1_reg.is_inf;
        s2_next.is_nan  = s1_reg.is_nan;
        s2_next.is_snan = s1_reg.is_snan;
        s2_next.is_zero = s1_reg.is_zero;
        s2_next.tiny    = s1_reg.is_sub && (s1_reg.e < -10'sd1);
        if (s1_reg.func == rre_pkg::FUNC_RSQ)
            s2_next.os = {rsq_tab[idx_rsq], {(SB - EST_BITS){1'b0}}};
        else
            s2_next.os = {rcp_tab[idx_rcp], {(SB - EST_BITS){1'b0}}};
        s2_next.oe_rcp  = 10'sd253 - s1_reg.e;
        s2_next.oe_rsq  = 8'((10'sd380 - s1_reg.e) >>> 1);
    end

    // stage 3: special cases and result
    logic clamp_max;

    always_comb
    begin
        clamp_max = (s2_reg.rm == rre_pkg::RM_RTZ)
                 || (s2_reg.rm == rre_pkg::RM_RDN && !s2_reg.sign)
                 || (s2_reg.rm == rre_pkg::RM_RUP && s2_reg.sign);
        s3_next   = '0;
        if (s2_reg.is_inf)
        begin
            if (s2_reg.func == rre_pkg::FUNC_RSQ && s2_reg.sign)
            begin
                s3_next.result       = rre_pkg::QNAN_BITS;
                s3_next.flag_invalid = 1'b1;
            end
            else
                s3_next.result = {s2_reg.sign, 31'd0};
        end
        else if (s2_reg.is_nan)
        begin
            s3_next.result       = rre_pkg::QNAN_BITS;
            s3_next.flag_invalid = s2_reg.is_snan;
        end
        else if (s2_reg.is_zero)
        begin
            s3_next.result        = {s2_reg.sign, 31'd0} | rre_pkg::INF_BITS;
            s3_next.flag_div_zero = 1'b1;
        end
        else if (s2_reg.func == rre_pkg::FUNC_RSQ)
        begin
            if (s2_reg.sign)
            begin
                s3_next.result       = rre_pkg::QNAN_BITS;
                s3_next.flag_invalid = 1'b1;
            end
            else
                s3_next.result = {1'b0, s2_reg.oe_rsq, s2_reg.os};
        end
        else if (s2_reg.tiny)
        begin
            s3_next.flag_overflow = 1'b1;
            s3_next.flag_inexact  = 1'b1;
            s3_next.result = {s2_reg.sign, 31'd0}
                           | (clamp_max ? rre_pkg::MAXF_BITS : rre_pkg::INF_BITS);
        end
        else if (s2_reg.oe_rcp == 10'sd0)
            s3_next.result = {s2_reg.sign, 8'd0, 1'b1, s2_reg.os[SB-1:1]};
        else if (s2_reg.oe_rcp == -10'sd1)
            s3_next.result = {s2_reg.sign, 8'd0, 2'b01, s2_reg.os[SB-1:2]};
        else
            s3_next.result = {s2_reg.sign, s2_reg.oe_rcp[7:0], s2_reg.os};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= req.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
            s1_reg <= s1_next;
        if (rdy2)
            s2_reg <= s2_next;
        if (rdy3)
            s3_reg <= s3_next;
    end

    assign rsp.valid         = v3_reg;
    assign rsp.result        = s3_reg.result;
    assign rsp.flag_invalid  = s3_reg.flag_invalid;
    assign rsp.flag_div_zero = s3_reg.flag_div_zero;
    assign rsp.flag_overflow = s3_reg.flag_overflow;
    assign rsp.flag_inexact  = s3_reg.flag_inexact;

endmodule
